### rtl/clr_pkg.sv
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types and constants for the clipped line rasterizer: request and
// pixel write records, walk modes, opcodes and register indexes.
// ----------------------------------------------------------------------------
package clr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int DIM_BITS    = 12;
    localparam int COLOR_BITS  = 32;
    localparam int ERR_BITS    = COORD_BITS + 1;
    localparam int CMP_BITS    = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
    localparam int MAX_WRITES  = 3;
    localparam int WCNT_BITS   = $clog2(MAX_WRITES + 1);
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RESET  = DIM_BITS'(800);
    localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET = DIM_BITS'(600);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        WALK_DOT = 2'd0,
        WALK_Y   = 2'd1,
        WALK_X   = 2'd2
    } walk_t;

    typedef enum logic
    {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        op_t                   op;
        coord_t                start_x;
        coord_t                start_y;
        coord_t                end_x;
        coord_t                end_y;
        logic [COLOR_BITS-1:0] line_color;
    } req_t;

    typedef struct packed
    {
        coord_t                pixel_x;
        coord_t                pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  write_enable;
        logic                  last;
    } pix_t;

    // Writes caused by one request, slot 0 first; count says how many are live.
    typedef struct packed
    {
        logic [WCNT_BITS-1:0]    count;
        pix_t [MAX_WRITES-1:0]   wr;
    } push_t;

endpackage

### rtl/clr_walk.sv
// ----------------------------------------------------------------------------
// clr_walk
// Line walk state and single-pass step logic. A start request loads the
// endpoints; each step request produces up to three pixel writes.
// ----------------------------------------------------------------------------
module clr_walk
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  clr_pkg::req_t             req,
    input  logic [clr_pkg::DIM_BITS-1:0] screen_width,
    input  logic [clr_pkg::DIM_BITS-1:0] screen_height,
    output clr_pkg::push_t            push
);
    import clr_pkg::*;

    logic                  busy_reg,    busy_next;
    walk_t                 mode_reg,    mode_next;
    coord_t                cur_x_reg,   cur_x_next;
    coord_t                cur_y_reg,   cur_y_next;
    coord_t                stop_x_reg,  stop_x_next;
    coord_t                stop_y_reg,  stop_y_next;
    logic [COORD_BITS-1:0] major_reg,   major_next;
    logic [COORD_BITS-1:0] minor_reg,   minor_next;
    logic [ERR_BITS-1:0]   err_reg,     err_next;
    logic                  dir_neg_reg, dir_neg_next;
    logic [COLOR_BITS-1:0] color_reg,   color_next;

    function automatic logic on_screen(coord_t x, coord_t y,
                                       logic [DIM_BITS-1:0] w,
                                       logic [DIM_BITS-1:0] h);
        logic x_ok;
        logic y_ok;
        x_ok = !x[COORD_BITS-1] && (CMP_BITS'($unsigned(x)) < CMP_BITS'(w));
        y_ok = !y[COORD_BITS-1] && (CMP_BITS'($unsigned(y)) < CMP_BITS'(h));
        return x_ok && y_ok;
    endfunction

    function automatic logic [COORD_BITS-1:0] abs_diff(coord_t a, coord_t b);
        logic signed [COORD_BITS:0] d;
        d = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
        return d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
    endfunction

    always_comb
    begin
        pix_t                  w;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic                  swap;
        coord_t                ax;
        coord_t                ay;
        coord_t                bx;
        coord_t                by;
        logic                  is_y;
        coord_t                maj_cur;
        coord_t                min_cur;
        coord_t                maj_stop;
        coord_t                step;
        logic [ERR_BITS-1:0]   e1;
        logic [WCNT_BITS-1:0]  n;

        busy_next    = busy_reg;
        mode_next    = mode_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        stop_x_next  = stop_x_reg;
        stop_y_next  = stop_y_reg;
        major_next   = major_reg;
        minor_next   = minor_reg;
        err_next     = err_reg;
        dir_neg_next = dir_neg_reg;
        color_next   = color_reg;
        push         = '0;
        n            = '0;

        w.pixel_color  = color_reg;
        w.pixel_x      = cur_x_reg;
        w.pixel_y      = cur_y_reg;
        w.write_enable = 1'b0;
        w.last         = 1'b0;

        dx   = abs_diff(req.start_x, req.end_x);
        dy   = abs_diff(req.start_y, req.end_y);
        swap = (dx >= dy) ? (req.end_x < req.start_x) : (req.end_y < req.start_y);
        ax   = swap ? req.end_x   : req.start_x;
        ay   = swap ? req.end_y   : req.start_y;
        bx   = swap ? req.start_x : req.end_x;
        by   = swap ? req.start_y : req.end_y;

        is_y     = (mode_reg == WALK_Y);
        maj_cur  = is_y ? cur_y_reg  : cur_x_reg;
        min_cur  = is_y ? cur_x_reg  : cur_y_reg;
        maj_stop = is_y ? stop_y_reg : stop_x_reg;
        step     = dir_neg_reg ? coord_t'(-1) : coord_t'(1);
        e1       = err_reg + ERR_BITS'(minor_reg);

        if (take && req.op == OP_START)
        begin
            busy_next    = 1'b1;
            color_next   = req.line_color;
            err_next     = '0;
            minor_next   = '0;
            dir_neg_next = 1'b0;
            cur_x_next   = req.start_x;
            cur_y_next   = req.start_y;
            stop_x_next  = req.end_x;
            stop_y_next  = req.end_y;
            if (req.start_x == req.end_x && req.start_y == req.end_y)
            begin
                mode_next  = WALK_DOT;
                major_next = '0;
            end
            else if (req.start_x == req.end_x)
            begin
                mode_next    = WALK_Y;
                major_next   = dy;
                dir_neg_next = req.start_y > req.end_y;
            end
            else if (req.start_y == req.end_y)
            begin
                mode_next    = WALK_X;
                major_next   = dx;
                dir_neg_next = req.start_x > req.end_x;
            end
            else
            begin
                // Swap endpoints so the major coordinate always increases.
                cur_x_next  = ax;
                cur_y_next  = ay;
                stop_x_next = bx;
                stop_y_next = by;
                if (dx >= dy)
                begin
                    mode_next    = WALK_X;
                    major_next   = dx;
                    minor_next   = dy;
                    dir_neg_next = by < ay;
                end
                else
                begin
                    mode_next    = WALK_Y;
                    major_next   = dy;
                    minor_next   = dx;
                    dir_neg_next = bx < ax;
                end
            end
        end
        else if (take && busy_reg)
        begin
            case (mode_reg)
                WALK_X, WALK_Y:
                begin
                    if (minor_reg == '0)
                    begin
                        if (maj_cur == maj_stop)
                        begin
                            w.pixel_x = stop_x_reg;
                            w.pixel_y = stop_y_reg;
                            w.last    = 1'b1;
                            busy_next = 1'b0;
                        end
                        else
                        begin
                            maj_cur = maj_cur + step;
                        end
                        w.write_enable = on_screen(w.pixel_x, w.pixel_y,
                                                   screen_width, screen_height);
                        push.wr[0] = w;
                        n          = WCNT_BITS'(1);
                    end
                    else
                    begin
                        w.write_enable = on_screen(w.pixel_x, w.pixel_y,
                                                   screen_width, screen_height);
                        push.wr[0] = w;
                        n          = WCNT_BITS'(1);
                        err_next   = e1;
                        if (e1 >= ERR_BITS'(major_reg))
                        begin
                            err_next  = e1 - ERR_BITS'(major_reg);
                            min_cur   = min_cur + step;
                            w.pixel_x = is_y ? min_cur : maj_cur;
                            w.pixel_y = is_y ? maj_cur : min_cur;
                            w.write_enable = on_screen(w.pixel_x, w.pixel_y,
                                                       screen_width, screen_height);
                            push.wr[n] = w;
                            n          = n + WCNT_BITS'(1);
                        end
                        if (maj_cur == maj_stop)
                        begin
                            // Final endpoint goes out once more, flagged last.
                            w.pixel_x = stop_x_reg;
                            w.pixel_y = stop_y_reg;
                            w.last    = 1'b1;
                            w.write_enable = on_screen(w.pixel_x, w.pixel_y,
                                                       screen_width, screen_height);
                            push.wr[n] = w;
                            n          = n + WCNT_BITS'(1);
                            busy_next  = 1'b0;
                        end
                        else
                        begin
                            maj_cur = maj_cur + coord_t'(1);
                        end
                    end
                    cur_x_next = is_y ? min_cur : maj_cur;
                    cur_y_next = is_y ? maj_cur : min_cur;
                end
                default:
                begin
                    w.last         = 1'b1;
                    w.write_enable = on_screen(w.pixel_x, w.pixel_y,
                                               screen_width, screen_height);
                    push.wr[0] = w;
                    n          = WCNT_BITS'(1);
                    busy_next  = 1'b0;
                end
            endcase
        end
        push.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mode_reg <= WALK_DOT;
        end
        else
        begin
            busy_reg <= busy_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        stop_x_reg  <= stop_x_next;
        stop_y_reg  <= stop_y_next;
        major_reg   <= major_next;
        minor_reg   <= minor_next;
        err_reg     <= err_next;
        dir_neg_reg <= dir_neg_next;
        color_reg   <= color_next;
    end

endmodule

### rtl/clr_outq.sv
// ----------------------------------------------------------------------------
// clr_outq
// Pixel write queue. Takes up to three writes per cycle from the walk and
// hands them out one per unstalled cycle. DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module clr_outq
#(
    parameter int DEPTH = clr_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  clr_pkg::push_t push,
    output logic           full,
    output logic           pix_valid,
    input  logic           pix_stall,
    output clr_pkg::pix_t  pix_data
);
    import clr_pkg::*;

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    pix_t                mem_reg [DEPTH];
    logic [PTR_BITS-1:0] head_reg,  head_next;
    logic [PTR_BITS-1:0] tail_reg,  tail_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                pop;

    assign pop       = pix_valid && !pix_stall;
    assign pix_valid = (count_reg != '0);
    assign pix_data  = mem_reg[head_reg];
    // Hold off requests unless a full batch of writes still fits.
    assign full      = count_reg > CNT_BITS'(DEPTH - MAX_WRITES);

    always_comb
    begin
        head_next  = head_reg + PTR_BITS'(pop);
        tail_next  = tail_reg + PTR_BITS'(push.count);
        count_next = count_reg + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_WRITES; i++)
        begin
            if (i < int'(push.count))
            begin
                mem_reg[tail_reg + PTR_BITS'(i)] <= push.wr[i];
            end
        end
    end

endmodule

### rtl/clipped_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_top
// Line rasterizer with screen-bound write enables.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req_data): a start request loads
//   both endpoints and the color and produces no write; each step request
//   advances the line one position along its major axis and produces one
//   to three pixel writes. A step with no line in progress produces nothing.
//   pix channel (pix_valid / pix_stall / pix_data): one pixel write per
//   transfer; write_enable is low for pixels off the screen, last marks the
//   final write of a line.
//   A request's writes are registered into the write queue when it is
//   taken and leave in order behind any writes already queued. Requests
//   are taken one per cycle while req_stall is low; the sustained rate is
//   bounded by the pix port, one write per cycle.
//   A four-entry write queue sits between the walk and the pix port;
//   req_stall rises while fewer than three entries are free, so a full batch
//   of writes always fits. With the receiver stalled, requests back up once
//   two writes are waiting. Screen size registers are written through
//   cfg_write / cfg_index / cfg_data; the user does so only while no line is
//   in flight, which the block does not enforce. Reset empties the queue,
//   ends any line and sets the screen to 800 by 600.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_top
#(
    parameter int QUEUE_DEPTH = clr_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  clr_pkg::req_t                req_data,
    output logic                         pix_valid,
    input  logic                         pix_stall,
    output clr_pkg::pix_t                pix_data,
    input  logic                         cfg_write,
    input  clr_pkg::cfg_index_t          cfg_index,
    input  logic [clr_pkg::DIM_BITS-1:0] cfg_data
);
    import clr_pkg::*;

    logic [DIM_BITS-1:0] width_reg,  width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic                take;
    logic                full;
    push_t               push;

    assign take      = req_valid && !req_stall;
    assign req_stall = full;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  width_next  = cfg_data;
                CFG_SCREEN_HEIGHT: height_next = cfg_data;
                default:           width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RESET;
            height_reg <= SCREEN_HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    clr_walk u_walk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .req           (req_data),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .push          (push)
    );

    clr_outq
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data)
    );

endmodule

### rtl/clr_checker.sv
// ----------------------------------------------------------------------------
// clr_checker
// Port-level checks for the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module clr_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_stall,
    input clr_pkg::req_t                req_data,
    input logic                         pix_valid,
    input logic                         pix_stall,
    input clr_pkg::pix_t                pix_data,
    input logic                         cfg_write,
    input clr_pkg::cfg_index_t          cfg_index,
    input logic [clr_pkg::DIM_BITS-1:0] cfg_data
);
    import clr_pkg::*;

    // Stalled write holds.
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(pix_data))
        else $error("pixel write changed while stalled");

    // Off-screen negative coordinates never enable a write.
    a_enable_sign: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_data.write_enable |->
            !pix_data.pixel_x[COORD_BITS-1] && !pix_data.pixel_y[COORD_BITS-1])
        else $error("write enabled at negative coordinate");

    // A start request produces no write.
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_data.op == OP_START && !pix_valid
            |=> !pix_valid)
        else $error("start request produced a write");

    // An empty write queue always takes a request.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_valid |-> !req_stall)
        else $error("request stalled with no writes pending");

    // Register writes land only while no pixel write is pending.
    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |-> !pix_valid && !$isunknown({cfg_index, cfg_data}))
        else $error("register write with pixel writes pending");

endmodule

bind clipped_line_rasterizer_top clr_checker u_clr_checker (.*);

### bench/clipped_line_rasterizer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_top_tb
// Self-checking bench for the clipped line rasterizer. Requests come from a
// queue through a valid/stall driver; every pixel write leaving the block is
// compared field by field against a cycle-free line walker kept in the bench.
// Directed lines cover dots, straight lines, coordinate wrap and the range
// extremes; random, mostly short lines then run under several screen sizes
// and sender/receiver idle patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_top_tb;

    import clr_pkg::*;

    localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
    // Quiet cycles after the last result before the block counts as idle.
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 120;
    // Longest legal quiet stretch is the hold-off plus a random gap.
    localparam int WATCHDOG_LIMIT = 2000;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    req_t          req_data  = '0;
    logic          pix_valid;
    logic          pix_stall = 1'b0;
    pix_t          pix_data;
    logic          cfg_write = 1'b0;
    cfg_index_t    cfg_index = CFG_SCREEN_WIDTH;
    logic [DIM_BITS-1:0] cfg_data = '0;

    clipped_line_rasterizer_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Line walker state
    logic [DIM_BITS-1:0]   clip_width  = SCREEN_WIDTH_RESET;
    logic [DIM_BITS-1:0]   clip_height = SCREEN_HEIGHT_RESET;
    logic                  line_active = 1'b0;
    walk_t                 walk        = WALK_DOT;
    logic [COORD_BITS-1:0] pos_x = '0, pos_y = '0, end_px = '0, end_py = '0;
    logic [COORD_BITS-1:0] major_len = '0, minor_len = '0;
    logic [ERR_BITS-1:0]   err_acc   = '0;
    logic                  minor_down = 1'b0;
    logic [COLOR_BITS-1:0] color_hold = '0;

    req_t pending_reqs[$];
    pix_t expected_pixels[$];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    bit          hold_request  = 1'b0;
    int unsigned hold_left     = 0;
    bit          req_taken     = 1'b0;

    int reqs_queued    = 0;
    int reqs_accepted  = 0;
    int pixels_checked = 0;
    int clipped_writes = 0;
    int lines_drawn    = 0;
    int fail_count     = 0;
    int idle_cycles    = 0;

    function automatic void push_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                       logic is_last);
        pix_t p;
        int   sx;
        int   sy;
        sx = $signed(x);
        sy = $signed(y);
        p.pixel_x      = x;
        p.pixel_y      = y;
        p.pixel_color  = color_hold;
        p.write_enable = (sx >= 0 && sx < int'(clip_width) &&
                          sy >= 0 && sy < int'(clip_height));
        p.last         = is_last;
        expected_pixels.push_back(p);
    endfunction

    function automatic void rasterize_request(req_t r);
        int x1, y1, x2, y2, dx, dy, t;
        logic                  along_y;
        logic [COORD_BITS-1:0] maj, mnr, maj_stop;
        if (r.op == OP_START)
        begin
            color_hold = r.line_color;
            x1 = r.start_x;
            y1 = r.start_y;
            x2 = r.end_x;
            y2 = r.end_y;
            dx = (x1 < x2) ? x2 - x1 : x1 - x2;
            dy = (y1 < y2) ? y2 - y1 : y1 - y2;
            err_acc    = '0;
            minor_len  = '0;
            minor_down = 1'b0;
            if (x1 == x2 && y1 == y2)
            begin
                walk      = WALK_DOT;
                major_len = '0;
            end
            else if (x1 == x2)
            begin
                walk       = WALK_Y;
                major_len  = dy[COORD_BITS-1:0];
                minor_down = (y1 > y2);
            end
            else if (y1 == y2)
            begin
                walk       = WALK_X;
                major_len  = dx[COORD_BITS-1:0];
                minor_down = (x1 > x2);
            end
            else if (dx >= dy)
            begin
                // walk x upward: swap ends when the line runs leftward
                if (x2 < x1)
                begin
                    t = x1; x1 = x2; x2 = t;
                    t = y1; y1 = y2; y2 = t;
                end
                walk       = WALK_X;
                major_len  = dx[COORD_BITS-1:0];
                minor_len  = dy[COORD_BITS-1:0];
                minor_down = (y2 < y1);
            end
            else
            begin
                if (y2 < y1)
                begin
                    t = x1; x1 = x2; x2 = t;
                    t = y1; y1 = y2; y2 = t;
                end
                walk       = WALK_Y;
                major_len  = dy[COORD_BITS-1:0];
                minor_len  = dx[COORD_BITS-1:0];
                minor_down = (x2 < x1);
            end
            pos_x       = x1[COORD_BITS-1:0];
            pos_y       = y1[COORD_BITS-1:0];
            end_px      = x2[COORD_BITS-1:0];
            end_py      = y2[COORD_BITS-1:0];
            line_active = 1'b1;
        end
        else if (line_active)
        begin
            if (walk != WALK_X && walk != WALK_Y)
            begin
                push_pixel(pos_x, pos_y, 1'b1);
                line_active = 1'b0;
            end
            else
            begin
                along_y  = (walk == WALK_Y);
                maj      = along_y ? pos_y : pos_x;
                mnr      = along_y ? pos_x : pos_y;
                maj_stop = along_y ? end_py : end_px;
                if (minor_len == '0)
                begin
                    // straight line: direction flag applies to the major axis
                    if (maj == maj_stop)
                    begin
                        push_pixel(end_px, end_py, 1'b1);
                        line_active = 1'b0;
                    end
                    else
                    begin
                        push_pixel(pos_x, pos_y, 1'b0);
                        maj = minor_down ? maj - 1'b1 : maj + 1'b1;
                    end
                end
                else
                begin
                    push_pixel(pos_x, pos_y, 1'b0);
                    err_acc = err_acc + {1'b0, minor_len};
                    if (err_acc >= {1'b0, major_len})
                    begin
                        err_acc = err_acc - {1'b0, major_len};
                        mnr = minor_down ? mnr - 1'b1 : mnr + 1'b1;
                        push_pixel(along_y ? mnr : maj, along_y ? maj : mnr, 1'b0);
                    end
                    if (maj == maj_stop)
                    begin
                        push_pixel(end_px, end_py, 1'b1);
                        line_active = 1'b0;
                    end
                    else
                        maj = maj + 1'b1;
                end
                pos_x = along_y ? mnr : maj;
                pos_y = along_y ? maj : mnr;
            end
        end
    endfunction

    function automatic void check_pixel(pix_t got);
        pix_t want;
        if (expected_pixels.size() == 0)
        begin
            $error("unexpected pixel write at (%0d,%0d)", got.pixel_x, got.pixel_y);
            fail_count++;
            return;
        end
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (want.last)
            lines_drawn++;
        if (!want.write_enable)
            clipped_writes++;
        if (got.pixel_x !== want.pixel_x)
        begin
            $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
            fail_count++;
        end
        if (got.pixel_y !== want.pixel_y)
        begin
            $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
            fail_count++;
        end
        if (got.pixel_color !== want.pixel_color)
        begin
            $error("pixel_color: expected %h, got %h", want.pixel_color, got.pixel_color);
            fail_count++;
        end
        if (got.write_enable !== want.write_enable)
        begin
            $error("write_enable: expected %b, got %b", want.write_enable, got.write_enable);
            fail_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %b, got %b", want.last, got.last);
            fail_count++;
        end
    endfunction

    // Request driver: hold a stalled request, otherwise offer the next one
    always @(negedge clk)
    begin : drive_requests
        logic was_taken;
        was_taken = req_taken;
        if (was_taken)
        begin
            void'(pending_reqs.pop_front());
            req_taken = 1'b0;
        end
        if (!req_valid || was_taken)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_valid <= 1'b1;
                req_data  <= pending_reqs[0];
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver stall, with an occasional long hold-off
    always @(negedge clk)
    begin : drive_stall
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            pix_stall <= 1'b1;
        end
        else
            pix_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : watch_ports
        logic moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                rasterize_request(req_data);
                req_taken = 1'b1;
                reqs_accepted++;
                moved = 1'b1;
            end
            if (pix_valid && !pix_stall)
            begin
                check_pixel(pix_data);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic int rand_coord();
        return int'($urandom_range(2 * COORD_MAX + 1)) + COORD_MIN;
    endfunction

    function automatic int clamp_coord(int v);
        return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic void queue_request(op_t op, int sx, int sy, int ex, int ey,
                                          logic [COLOR_BITS-1:0] color);
        req_t r;
        r.op         = op;
        r.start_x    = coord_t'(sx);
        r.start_y    = coord_t'(sy);
        r.end_x      = coord_t'(ex);
        r.end_y      = coord_t'(ey);
        r.line_color = color;
        pending_reqs.push_back(r);
        reqs_queued++;
    endfunction

    // Step payload fields are ignored by the block; fill them with noise.
    function automatic void queue_steps(int n);
        repeat (n)
            queue_request(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          $urandom);
    endfunction

    function automatic void queue_random_lines(int target);
        int issued, roll, shape, span, x1, y1, x2, y2, n_steps;
        issued = 0;
        while (issued < target)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
                queue_steps(1);
            else
            begin
                if (roll < 16)
                begin
                    // long line anywhere: walk a few steps, then abandon it
                    x1 = rand_coord();
                    y1 = rand_coord();
                    x2 = rand_coord();
                    y2 = rand_coord();
                    n_steps = $urandom_range(1, 3);
                end
                else
                begin
                    span = (roll < 26) ? 40 : 6;
                    if ($urandom_range(1))
                    begin
                        x1 = int'($urandom_range(48)) - 8;
                        y1 = int'($urandom_range(48)) - 8;
                    end
                    else
                    begin
                        x1 = rand_coord();
                        y1 = rand_coord();
                    end
                    x2 = clamp_coord(x1 + int'($urandom_range(2 * span)) - span);
                    y2 = clamp_coord(y1 + int'($urandom_range(2 * span)) - span);
                    shape = $urandom_range(9);
                    if (shape == 0)
                    begin
                        x2 = x1;
                        y2 = y1;
                    end
                    else if (shape == 1)
                        x2 = x1;
                    else if (shape == 2)
                        y2 = y1;
                    n_steps = ((x2 > x1) ? x2 - x1 : x1 - x2);
                    if (((y2 > y1) ? y2 - y1 : y1 - y2) > n_steps)
                        n_steps = (y2 > y1) ? y2 - y1 : y1 - y2;
                    n_steps = n_steps + 1;
                    shape = $urandom_range(9);
                    if (shape == 0)
                        n_steps = $urandom_range(n_steps - 1);
                    else if (shape == 1)
                        n_steps = n_steps + 1;
                end
                queue_request(OP_START, x1, y1, x2, y2, $urandom);
                queue_steps(n_steps);
                issued += 1 + n_steps;
            end
        end
    endfunction

    task automatic wait_for_drain();
        @(negedge clk);
        while (reqs_accepted != reqs_queued || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_screen(int width, int height);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data  <= DIM_BITS'(width);
        @(negedge clk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data  <= DIM_BITS'(height);
        @(negedge clk);
        cfg_write <= 1'b0;
        clip_width  = DIM_BITS'(width);
        clip_height = DIM_BITS'(height);
    endtask

    task automatic run_phase(int send_pct, int stall_in_pct, int width, int height,
                             int n_items, bit hold_off);
        write_screen(width, height);
        @(posedge clk);
        send_idle_pct = send_pct;
        stall_pct     = stall_in_pct;
        if (hold_off)
            hold_request = 1'b1;
        queue_random_lines(n_items);
        wait_for_drain();
    endtask

    initial
    begin : stimulus
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step with no line in progress
        queue_steps(1);
        queue_request(OP_START, 799, 599, 799, 599, 32'hA5A5_5A5A);
        queue_steps(1);
        queue_request(OP_START, 3, -1, 3, 0, 32'h0000_0000);
        queue_steps(2);
        // leftward horizontal crossing the right screen edge
        queue_request(OP_START, 800, 5, 798, 5, 32'h1234_5678);
        queue_steps(3);
        // diagonal whose minor coordinate wraps past the top of the range
        queue_request(OP_START, 2045, 2045, 2047, 2047, 32'hFFFF_FFFF);
        queue_steps(3);
        // swapped diagonal whose minor coordinate wraps past the bottom
        queue_request(OP_START, 2047, -2048, 2045, -2046, 32'h0F0F_F0F0);
        queue_steps(3);
        // full-range line, abandoned by the next start
        queue_request(OP_START, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 32'h8000_0001);
        queue_steps(1);
        // steep line running downward: walked from the other end
        queue_request(OP_START, 2, 3, 0, 0, 32'hCAFE_0042);
        queue_steps(5);
        wait_for_drain();

        run_phase(0, 0, 64, 48, 25, 1'b0);
        run_phase(82, 0, 2048, 2048, 25, 1'b0);
        run_phase(0, 82, 1, 1, 25, 1'b0);
        run_phase(29, 29, 0, 4095, 25, 1'b0);
        run_phase(0, 0, 100, 2047, 25, 1'b1);
        run_phase(29, 29, 800, 600, 25, 1'b0);

        $display("Covered %0d requests and %0d pixel writes (%0d clipped, %0d lines ended)",
                 reqs_accepted, pixels_checked, clipped_writes, lines_drawn);
        $display("over six screen sizes, four idle patterns and one long output hold-off");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### clipped_line_rasterizer_top.f
rtl/clr_pkg.sv
rtl/clr_walk.sv
rtl/clr_outq.sv
rtl/clipped_line_rasterizer_top.sv
rtl/clr_checker.sv
bench/clipped_line_rasterizer_top_tb.sv
